// ----- rtl/irpfd_pkg.sv -----
// shared constants, types and size helpers for the ir pulse frame decoder
package irpfd_pkg;

	localparam int DUR_W      = 15;
	localparam int CNT_W      = 10;
	localparam int IDLE_W     = 8;
	localparam int CODING_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int BYTE_IDX_W = 6;
	localparam int STORE_BITS = 512;
	localparam int WORD_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam int MAX_SYMBOLS_DEF = 256;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS = 2'd2;

	localparam logic [DUR_W-1:0]  BIT_TH_RST     = 15'd800;
	localparam logic [DUR_W-1:0]  LEAD_TH_RST    = 15'd2000;
	localparam logic [IDLE_W-1:0] IDLE_TICKS_RST = 8'd3;

	localparam logic REQ_SYMBOL = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_IDLE = 1'b1;

	localparam logic [CODING_W-1:0] CODING_UNKNOWN = 2'd0;
	localparam logic [CODING_W-1:0] CODING_ZERO    = 2'd1;
	localparam logic [CODING_W-1:0] CODING_DIST    = 2'd2;
	localparam logic [CODING_W-1:0] CODING_LEN     = 2'd3;

	typedef struct packed {
		logic                frame;
		logic                idle;
		logic [CODING_W-1:0] coding;
		logic [CNT_W-1:0]    total;
		logic [DUR_W-1:0]    lead_mark;
		logic [DUR_W-1:0]    lead_space;
	} emit_req_t;

	function automatic int bit_cap(input int max_symbols);
		return (2 * max_symbols > STORE_BITS) ? STORE_BITS : 2 * max_symbols;
	endfunction

	function automatic int word_depth(input int max_symbols);
		return (bit_cap(max_symbols) + WORD_W - 1) / WORD_W;
	endfunction

	function automatic int addr_w(input int max_symbols);
		return (word_depth(max_symbols) > 1) ? $clog2(word_depth(max_symbols)) : 1;
	endfunction

endpackage

// ----- rtl/irpfd_ram.sv -----
// generic single write port ram with registered read
module irpfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/irpfd_collect.sv -----
// symbol intake: bit slicing, word assembly into the bit store, leader and idle tracking
module irpfd_collect
	import irpfd_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int AW          = addr_w(MAX_SYMBOLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [DUR_W-1:0]  mark_us,
	input  logic [DUR_W-1:0]  space_us,
	input  logic              frame_end,
	input  logic [DUR_W-1:0]  bit_th,
	input  logic [DUR_W-1:0]  lead_th,
	input  logic [IDLE_W-1:0] idle_ticks,
	input  logic              emit_ready,
	output emit_req_t         emit_req,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [WORD_W-1:0] ram_wdata
);

	localparam int BIT_CAP = bit_cap(MAX_SYMBOLS);

	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic [WORD_W-1:0] word_q, word_nxt;
	logic              any_even_q, any_odd_q, any_even_nxt, any_odd_nxt;
	logic [DUR_W-1:0]  lead_mark_q, lead_space_q;
	logic              start_q;
	logic [IDLE_W-1:0] idle_q;

	logic       accept, is_sym, is_tick;
	logic       lead_hit, mark_bit, space_bit, space_push, room, push;
	logic [1:0] inc;
	logic [3:0] pos;
	logic       idle_fire;

	assign in_stall = ~emit_ready;
	assign accept   = in_valid & emit_ready;
	assign is_sym   = accept & (req_type == REQ_SYMBOL);
	assign is_tick  = accept & (req_type == REQ_TICK);

	assign lead_hit   = start_q & (mark_us > lead_th);
	assign mark_bit   = mark_us >= bit_th;
	assign space_bit  = space_us >= bit_th;
	// a zero space on the closing symbol is not a bit
	assign space_push = (space_us != '0) | ~frame_end;
	assign room       = cnt_q < CNT_W'(BIT_CAP);
	assign push       = ~lead_hit & room;
	assign pos        = cnt_q[3:0];
	assign inc        = push ? (space_push ? 2'd2 : 2'd1) : 2'd0;
	assign cnt_nxt    = cnt_q + CNT_W'(inc);

	// marks always land on even positions, so both bits share one word
	always_comb begin
		word_nxt = word_q;
		if (push) begin
			word_nxt[{pos[3:1], 1'b0}] = mark_bit;
			if (space_push) begin
				word_nxt[{pos[3:1], 1'b1}] = space_bit;
			end
		end
	end

	assign any_even_nxt = any_even_q | (push & mark_bit);
	assign any_odd_nxt  = any_odd_q | (push & space_push & space_bit);

	// write a full word, or the partial word at frame end
	assign ram_we    = is_sym & ((push & ((cnt_nxt[3:0] == 4'd0) | frame_end))
		| (frame_end & ~push & (pos != 4'd0)));
	assign ram_waddr = cnt_q[AW+3:4];
	assign ram_wdata = word_nxt;

	assign idle_fire = is_tick & (idle_q != '0) & (idle_q >= idle_ticks);

	always_comb begin
		emit_req            = '0;
		emit_req.frame      = is_sym & frame_end & (cnt_nxt != '0);
		emit_req.idle       = idle_fire;
		emit_req.lead_mark  = lead_hit ? mark_us : lead_mark_q;
		emit_req.lead_space = lead_hit ? space_us : lead_space_q;
		if (!(any_even_nxt | any_odd_nxt)) begin
			emit_req.coding = CODING_ZERO;
			emit_req.total  = cnt_nxt;
		end else if (!any_odd_nxt) begin
			emit_req.coding = CODING_LEN;
			emit_req.total  = cnt_nxt >> 1;
		end else if (!any_even_nxt) begin
			emit_req.coding = CODING_DIST;
			emit_req.total  = cnt_nxt >> 1;
		end else begin
			emit_req.coding = CODING_UNKNOWN;
			emit_req.total  = cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (is_sym) begin
			word_q <= word_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			any_even_q   <= 1'b0;
			any_odd_q    <= 1'b0;
			lead_mark_q  <= '0;
			lead_space_q <= '0;
			start_q      <= 1'b1;
			idle_q       <= '0;
		end else begin
			if (is_sym) begin
				if (frame_end) begin
					cnt_q        <= '0;
					any_even_q   <= 1'b0;
					any_odd_q    <= 1'b0;
					lead_mark_q  <= '0;
					lead_space_q <= '0;
					start_q      <= 1'b1;
					idle_q       <= IDLE_W'(1);
				end else begin
					cnt_q      <= cnt_nxt;
					any_even_q <= any_even_nxt;
					any_odd_q  <= any_odd_nxt;
					start_q    <= 1'b0;
					if (lead_hit) begin
						lead_mark_q  <= mark_us;
						lead_space_q <= space_us;
					end
				end
			end
			if (is_tick && idle_q != '0) begin
				if (idle_fire) begin
					idle_q <= '0;
				end else begin
					idle_q <= idle_q + IDLE_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/irpfd_emit.sv -----
// frame emission: walks the bit store with one word read per byte and drives the result register
module irpfd_emit
	import irpfd_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int AW          = addr_w(MAX_SYMBOLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  emit_req_t           emit_req,
	output logic                emit_ready,
	output logic                ram_re,
	output logic [AW-1:0]       ram_raddr,
	input  logic [WORD_W-1:0]   ram_rdata,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [CODING_W-1:0] coding,
	output logic [DUR_W-1:0]    lead_mark_us,
	output logic [DUR_W-1:0]    lead_space_us,
	output logic [CNT_W-1:0]    bit_total,
	output logic [BYTE_W-1:0]   data_byte,
	output logic                last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_BYTE = 2'd2;

	logic [1:0]            state_q;
	logic [CODING_W-1:0]   coding_q;
	logic [CNT_W-1:0]      total_q;
	logic [DUR_W-1:0]      lead_mark_q, lead_space_q;
	logic [BYTE_IDX_W-1:0] byte_idx_q, last_idx_q;

	logic                out_valid_q, kind_q, last_q;
	logic [CODING_W-1:0] out_coding_q;
	logic [DUR_W-1:0]    out_lead_mark_q, out_lead_space_q;
	logic [CNT_W-1:0]    out_total_q;
	logic [BYTE_W-1:0]   out_byte_q;

	logic                  out_free, raw, is_last, load_byte;
	logic [BYTE_W-1:0]     byte_sel, byte_mask;
	logic [2:0]            tail;
	logic [CNT_W-1:0]      total_m1;
	logic [BYTE_IDX_W-1:0] req_last_idx;

	function automatic logic [BYTE_W-1:0] pick_bits(input logic [WORD_W-1:0] w,
		input logic odd);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = w[2 * i + (odd ? 1 : 0)];
		end
		return r;
	endfunction

	assign out_free   = ~out_valid_q | ~out_stall;
	assign emit_ready = (state_q == ST_IDLE) & out_free;

	// raw codings pack two bytes per word, coded ones take one byte per word
	assign raw       = (coding_q == CODING_UNKNOWN) | (coding_q == CODING_ZERO);
	assign ram_re    = state_q == ST_READ;
	assign ram_raddr = raw ? byte_idx_q[AW:1] : byte_idx_q[AW-1:0];

	always_comb begin
		case (coding_q)
			CODING_LEN:  byte_sel = pick_bits(ram_rdata, 1'b0);
			CODING_DIST: byte_sel = pick_bits(ram_rdata, 1'b1);
			default:     byte_sel = byte_idx_q[0] ? ram_rdata[15:8] : ram_rdata[7:0];
		endcase
	end

	assign is_last = byte_idx_q == last_idx_q;
	assign tail    = total_q[2:0];

	always_comb begin
		byte_mask = '1;
		if (is_last) begin
			if (total_q == '0) begin
				byte_mask = '0;
			end else if (tail != 3'd0) begin
				byte_mask = ~(8'hFF << tail);
			end
		end
	end

	assign total_m1     = emit_req.total - CNT_W'(1);
	assign req_last_idx = (emit_req.total == '0) ? '0 : total_m1[8:3];
	assign load_byte    = (state_q == ST_BYTE) & out_free;

	always_ff @(posedge clk) begin
		if (emit_ready && emit_req.frame) begin
			coding_q     <= emit_req.coding;
			total_q      <= emit_req.total;
			lead_mark_q  <= emit_req.lead_mark;
			lead_space_q <= emit_req.lead_space;
			last_idx_q   <= req_last_idx;
		end
		if (emit_ready && emit_req.idle) begin
			kind_q           <= KIND_IDLE;
			out_coding_q     <= CODING_UNKNOWN;
			out_lead_mark_q  <= '0;
			out_lead_space_q <= '0;
			out_total_q      <= '0;
			out_byte_q       <= '0;
			last_q           <= 1'b1;
		end else if (load_byte) begin
			kind_q           <= KIND_DATA;
			out_coding_q     <= coding_q;
			out_lead_mark_q  <= lead_mark_q;
			out_lead_space_q <= lead_space_q;
			out_total_q      <= total_q;
			out_byte_q       <= byte_sel & byte_mask;
			last_q           <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((emit_ready && emit_req.idle) || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (emit_ready && emit_req.frame) begin
						byte_idx_q <= '0;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_BYTE;
				end
				ST_BYTE: begin
					if (out_free) begin
						byte_idx_q <= byte_idx_q + BYTE_IDX_W'(1);
						state_q    <= is_last ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign coding        = out_coding_q;
	assign lead_mark_us  = out_lead_mark_q;
	assign lead_space_us = out_lead_space_q;
	assign bit_total     = out_total_q;
	assign data_byte     = out_byte_q;
	assign last          = last_q;

endmodule

// ----- rtl/ir_pulse_frame_decoder.sv -----
// Top level of the ir pulse frame decoder: configuration registers, intake, bit store, emission.
// Each request (a mark/space duration pair or a timeout tick) is accepted while in_stall is low; the slicing
// of a symbol into bits, the leader check and the idle count all settle on the accepting edge.
// Sliced bits are packed into 16-bit words and written to a word RAM of ceil(min(2*MAX_SYMBOLS,
// 512)/16) entries with a registered read. A request that closes a nonempty frame starts
// emission, during which the input is stalled: each result byte takes a RAM read and then a load of
// the result register, which waits while the output is stalled. A frame yields max(1,
// ceil(bit_total/8)) result bytes (up to 64). An idle report is loaded directly into the result
// register on the accepting edge. The bit store needs no clearing pass after reset.
module ir_pulse_frame_decoder
	import irpfd_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [DUR_W-1:0]      mark_us,
	input  logic [DUR_W-1:0]      space_us,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  result_kind,
	output logic [CODING_W-1:0]   coding,
	output logic [DUR_W-1:0]      lead_mark_us,
	output logic [DUR_W-1:0]      lead_space_us,
	output logic [CNT_W-1:0]      bit_total,
	output logic [BYTE_W-1:0]     data_byte,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = addr_w(MAX_SYMBOLS);
	localparam int DEPTH = word_depth(MAX_SYMBOLS);

	logic [DUR_W-1:0]  bit_th_q, lead_th_q;
	logic [IDLE_W-1:0] idle_ticks_q;

	emit_req_t         emit_req;
	logic              emit_ready;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_th_q     <= BIT_TH_RST;
			lead_th_q    <= LEAD_TH_RST;
			idle_ticks_q <= IDLE_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BIT_TH:     bit_th_q     <= cfg_data[DUR_W-1:0];
				CFG_LEAD_TH:    lead_th_q    <= cfg_data[DUR_W-1:0];
				CFG_IDLE_TICKS: idle_ticks_q <= cfg_data[IDLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	irpfd_collect #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.AW          (AW)
	) u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.mark_us    (mark_us),
		.space_us   (space_us),
		.frame_end  (frame_end),
		.bit_th     (bit_th_q),
		.lead_th    (lead_th_q),
		.idle_ticks (idle_ticks_q),
		.emit_ready (emit_ready),
		.emit_req   (emit_req),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	irpfd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_bit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	irpfd_emit #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.AW          (AW)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit_req      (emit_req),
		.emit_ready    (emit_ready),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.coding        (coding),
		.lead_mark_us  (lead_mark_us),
		.lead_space_us (lead_space_us),
		.bit_total     (bit_total),
		.data_byte     (data_byte),
		.last          (last)
	);

endmodule
